/* hw/rtl/pfsl_pkg.sv */
// Shared types, constants and helper functions of the path-following steering law.
package pfsl_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;

    localparam int CW       = 34;                 // CORDIC x, y and angle width
    localparam int DW       = 33;                 // position difference width
    localparam int DPSI_W   = FRAC_BITS + 4;      // heading error in radians
    localparam int SAT_W    = 72;                 // width handed to the clipper
    localparam int STAGE_IW = 5;

    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [35:0]   TWO_PI_Q32      = 36'sd26986074949;
    localparam longint SPEED_EPS_INV  = 64'd10000000;
    localparam longint SPEED_ZERO_LIM =
        ((64'd1 << FRAC_BITS) + SPEED_EPS_INV - 64'd1) / SPEED_EPS_INV;

    typedef enum logic [1:0] {
        REG_ALONG_GAIN   = 2'd0,
        REG_CROSS_GAIN   = 2'd1,
        REG_HEADING_GAIN = 2'd2,
        REG_NONE         = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic        [15:0] robot_heading;
        logic signed [31:0] path_x;
        logic signed [31:0] path_y;
        logic signed [31:0] path_speed;
        logic        [15:0] path_heading;
        logic signed [31:0] path_curvature;
    } in_t;

    typedef struct packed {
        logic signed [31:0] speed_command;
        logic signed [31:0] turn_rate_command;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } cordic_t;

    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [31:0]   vdes;
        logic signed [15:0]   dpsi;
        logic signed [31:0]   curv;
    } pay_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic signed [CW-1:0] atan_turn(input logic [STAGE_IW-1:0] idx);
        logic [31:0] a;
        begin
            case (idx)
                5'd0:    a = 32'h20000000;
                5'd1:    a = 32'h12E4051E;
                5'd2:    a = 32'h09FB385B;
                5'd3:    a = 32'h051111D4;
                5'd4:    a = 32'h028B0D43;
                5'd5:    a = 32'h0145D7E1;
                5'd6:    a = 32'h00A2F61E;
                5'd7:    a = 32'h00517C55;
                5'd8:    a = 32'h0028BE53;
                5'd9:    a = 32'h00145F2F;
                5'd10:   a = 32'h000A2F98;
                5'd11:   a = 32'h000517CC;
                5'd12:   a = 32'h00028BE6;
                5'd13:   a = 32'h000145F3;
                5'd14:   a = 32'h0000A2FA;
                5'd15:   a = 32'h0000517D;
                5'd16:   a = 32'h000028BE;
                5'd17:   a = 32'h0000145F;
                5'd18:   a = 32'h00000A30;
                5'd19:   a = 32'h00000518;
                5'd20:   a = 32'h0000028C;
                5'd21:   a = 32'h00000146;
                5'd22:   a = 32'h000000A3;
                5'd23:   a = 32'h00000051;
                default: a = 32'h00000000;
            endcase
            atan_turn = $signed({2'b00, a});
        end
    endfunction

    // Clip to the signed 32-bit range; bit 32 of the result reports a clip.
    function automatic logic [32:0] sat32(input logic signed [SAT_W-1:0] v);
        begin
            if (v > $signed(SAT_W'(64'sh7FFFFFFF))) begin
                sat32 = {1'b1, 32'h7FFFFFFF};
            end else if (v < -$signed(SAT_W'(64'sh80000000))) begin
                sat32 = {1'b1, 32'h80000000};
            end else begin
                sat32 = {1'b0, v[31:0]};
            end
        end
    endfunction

endpackage

/* hw/rtl/pfsl_cordic_cell.sv */
// One rotation cell of the CORDIC chain, carrying the item's other fields along.
module pfsl_cordic_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic [pfsl_pkg::STAGE_IW-1:0]     stage_idx,
    input  logic                              in_valid,
    input  pfsl_pkg::cordic_t                 in_st,
    input  pfsl_pkg::pay_t                    in_pay,
    output logic                              out_valid,
    output pfsl_pkg::cordic_t                 out_st,
    output pfsl_pkg::pay_t                    out_pay
);

    logic              valid_reg;
    pfsl_pkg::cordic_t st_reg, st_next;
    pfsl_pkg::pay_t    pay_reg;
    logic signed [pfsl_pkg::CW-1:0] xs, ys, at;

    always_comb begin
        xs = in_st.x >>> stage_idx;
        ys = in_st.y >>> stage_idx;
        at = pfsl_pkg::atan_turn(stage_idx);
        st_next = in_st;
        if (!in_st.z[pfsl_pkg::CW-1]) begin
            st_next.x = in_st.x - ys;
            st_next.y = in_st.y + xs;
            st_next.z = in_st.z - at;
        end else begin
            st_next.x = in_st.x + ys;
            st_next.y = in_st.y - xs;
            st_next.z = in_st.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg  <= st_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_pay   = pay_reg;

    // The residual angle never leaves the 32-bit binary angle range.
    a_z_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (st_reg.z < 34'sh080000000) && (st_reg.z > -34'sh080000000))
        else $error("CORDIC residual angle out of range");

endmodule

/* hw/rtl/pfsl_law.sv */
// Error projection, gain products and saturation stages after the CORDIC chain.
module pfsl_law (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  pfsl_pkg::cordic_t  in_st,
    input  pfsl_pkg::pay_t     in_pay,
    input  logic signed [31:0] along_gain,
    input  logic signed [31:0] cross_gain,
    input  logic signed [31:0] heading_gain,
    output logic               out_valid,
    output pfsl_pkg::out_t     out_data
);

    localparam int PW = 32 + pfsl_pkg::DW;
    localparam int SW = pfsl_pkg::SAT_W;
    localparam int RW = 48 - pfsl_pkg::FRAC_BITS;

    // Stage 1: four projection products and the heading product.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [PW-1:0] pcx_reg, psy_reg, psx_reg, pcy_reg;
    logic signed [51:0]   pdp_reg;
    logic signed [31:0]   vdes1_reg, curv1_reg;
    logic                 vzero1_reg;
    logic signed [pfsl_pkg::CW-1:0] xf, yf;
    logic signed [31:0] cs, sn;
    logic [32:0] vmag;

    always_comb begin
        xf = in_st.flip ? -in_st.x : in_st.x;
        yf = in_st.flip ? -in_st.y : in_st.y;
        cs = xf[31:0];
        sn = yf[31:0];
        vmag = in_pay.vdes[31] ? -{1'b1, in_pay.vdes} : {1'b0, in_pay.vdes};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pcx_reg    <= PW'(cs) * PW'(in_pay.dx);
            psy_reg    <= PW'(sn) * PW'(in_pay.dy);
            psx_reg    <= PW'(sn) * PW'(in_pay.dx);
            pcy_reg    <= PW'(cs) * PW'(in_pay.dy);
            pdp_reg    <= 52'(in_pay.dpsi) * 52'(pfsl_pkg::TWO_PI_Q32);
            vdes1_reg  <= in_pay.vdes;
            curv1_reg  <= in_pay.curv;
            vzero1_reg <= vmag < 33'(pfsl_pkg::SPEED_ZERO_LIM);
        end
    end

    // Stage 2: along-track and cross-track errors, heading error in radians.
    logic signed [31:0] lf2_reg, d2_reg, vdes2_reg, curv2_reg;
    logic signed [pfsl_pkg::DPSI_W-1:0] dpr2_reg;
    logic vzero2_reg, clip2_reg;
    logic signed [SW-1:0] lf_sum, d_sum, dpr_full;
    logic [32:0] lf_sat, d_sat;

    always_comb begin
        lf_sum   = (SW'(pcx_reg) + SW'(psy_reg)) >>> 30;
        d_sum    = (SW'(psx_reg) - SW'(pcy_reg)) >>> 30;
        dpr_full = SW'(pdp_reg) >>> RW;
        lf_sat   = pfsl_pkg::sat32(lf_sum);
        d_sat    = pfsl_pkg::sat32(d_sum);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lf2_reg    <= lf_sat[31:0];
            d2_reg     <= d_sat[31:0];
            dpr2_reg   <= dpr_full[pfsl_pkg::DPSI_W-1:0];
            clip2_reg  <= lf_sat[32] | d_sat[32];
            vdes2_reg  <= vdes1_reg;
            curv2_reg  <= curv1_reg;
            vzero2_reg <= vzero1_reg;
        end
    end

    // Stage 3: gain products.
    logic signed [63:0] pa3_reg, pc3_reg;
    logic signed [32+pfsl_pkg::DPSI_W-1:0] ph3_reg;
    logic signed [31:0] vdes3_reg, curv3_reg;
    logic vzero3_reg, clip3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa3_reg    <= 64'(along_gain) * 64'(lf2_reg);
            pc3_reg    <= 64'(cross_gain) * 64'(d2_reg);
            ph3_reg    <= (32+pfsl_pkg::DPSI_W)'(heading_gain)
                          * (32+pfsl_pkg::DPSI_W)'(dpr2_reg);
            vdes3_reg  <= vdes2_reg;
            curv3_reg  <= curv2_reg;
            vzero3_reg <= vzero2_reg;
            clip3_reg  <= clip2_reg;
        end
    end

    // Stage 4: speed command and commanded curvature.
    logic signed [31:0] v4_val_reg, rho4_reg;
    logic clip4_reg;
    logic signed [SW-1:0] v_sum, rho_sum;
    logic [32:0] v_sat, rho_sat;

    always_comb begin
        v_sum   = SW'(vdes3_reg) + (SW'(pa3_reg) >>> pfsl_pkg::FRAC_BITS);
        rho_sum = SW'(curv3_reg) - (SW'(pc3_reg) >>> pfsl_pkg::FRAC_BITS)
                  - (SW'(ph3_reg) >>> pfsl_pkg::FRAC_BITS);
        v_sat   = pfsl_pkg::sat32(v_sum);
        rho_sat = pfsl_pkg::sat32(rho_sum);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v4_val_reg <= vzero3_reg ? 32'sd0 : $signed(v_sat[31:0]);
            rho4_reg   <= rho_sat[31:0];
            clip4_reg  <= clip3_reg | rho_sat[32] | (!vzero3_reg & v_sat[32]);
        end
    end

    // Stage 5: turn-rate product.
    logic signed [63:0] pw5_reg;
    logic signed [31:0] v5_val_reg;
    logic clip5_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pw5_reg    <= 64'(v4_val_reg) * 64'(rho4_reg);
            v5_val_reg <= v4_val_reg;
            clip5_reg  <= clip4_reg;
        end
    end

    // Stage 6: output register.
    pfsl_pkg::out_t out_reg;
    logic [32:0] w_sat;

    always_comb begin
        w_sat = pfsl_pkg::sat32(SW'(pw5_reg) >>> pfsl_pkg::FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.speed_command     <= v5_val_reg;
            out_reg.turn_rate_command <= w_sat[31:0];
            out_reg.saturated         <= clip5_reg | w_sat[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = out_reg;

    // A zero speed command always yields a zero turn rate.
    a_zero_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        v6_reg && (out_reg.speed_command == 32'sd0) |-> out_reg.turn_rate_command == 32'sd0)
        else $error("nonzero turn rate with zero speed");

    // Items move one stage per advance and stay put otherwise.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> v6_reg == $past(v5_reg))
        else $error("output valid did not follow the last stage");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> v3_reg == $past(v3_reg) && v6_reg == $past(v6_reg))
        else $error("pipeline moved while stalled");

endmodule

/* hw/rtl/path_following_steering_law.sv */
// Top level of the path-following steering law: ports, gain registers and pipeline.
//
// One pose and path point per transfer go in, and one speed and turn-rate command
// pair comes out per transfer, in order. A new item can be taken in every cycle
// while the output is not stalled; an item passes through one entry stage, 16
// CORDIC rotation cells and six stages of projection, gain products and clipping.
// The whole pipeline moves as one: it advances whenever the output register is
// empty or its item is being taken, so s_ready drops only while a finished
// command waits at the output. The three gains are written through cfg_wr_en,
// cfg_index and cfg_data; index 0 is the along-track gain, 1 the cross-track gain
// and 2 the heading gain, and any other index is ignored. Write the gains only
// while no items are in flight. The saturated flag is set when the along-track
// error, cross-track error, commanded curvature, speed command or turn-rate
// command was clipped to the signed 32-bit range.
module path_following_steering_law (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pfsl_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output pfsl_pkg::out_t  m_data,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data
);

    localparam int N = pfsl_pkg::CORDIC_STAGES;

    // Gain registers.
    logic signed [31:0] along_gain_reg, cross_gain_reg, heading_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            along_gain_reg   <= 32'sd65536;
            cross_gain_reg   <= 32'sd16384;
            heading_gain_reg <= 32'sd65536;
        end else if (cfg_wr_en) begin
            case (pfsl_pkg::cfg_reg_t'(cfg_index))
                pfsl_pkg::REG_ALONG_GAIN:   along_gain_reg   <= cfg_data;
                pfsl_pkg::REG_CROSS_GAIN:   cross_gain_reg   <= cfg_data;
                pfsl_pkg::REG_HEADING_GAIN: heading_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances when the output register can take a new item.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Entry stage: position and heading differences and the CORDIC start vector.
    // The desired heading is folded into the right half plane; the flip bit
    // negates the rotated vector at the end of the chain.
    logic              pre_valid_reg;
    pfsl_pkg::cordic_t pre_st_reg, pre_st_next;
    pfsl_pkg::pay_t    pre_pay_reg, pre_pay_next;
    logic signed [pfsl_pkg::CW-1:0] z0;

    always_comb begin
        z0 = pfsl_pkg::CW'($signed({s_data.path_heading, 16'h0000}));
        pre_st_next.x    = pfsl_pkg::CORDIC_GAIN_Q30;
        pre_st_next.y    = '0;
        pre_st_next.z    = z0;
        pre_st_next.flip = 1'b0;
        if (z0 > 34'sh040000000) begin
            pre_st_next.z    = z0 - 34'sh080000000;
            pre_st_next.flip = 1'b1;
        end else if (z0 < -34'sh040000000) begin
            pre_st_next.z    = z0 + 34'sh080000000;
            pre_st_next.flip = 1'b1;
        end
        pre_pay_next.dx   = pfsl_pkg::DW'(s_data.path_x) - pfsl_pkg::DW'(s_data.robot_x);
        pre_pay_next.dy   = pfsl_pkg::DW'(s_data.path_y) - pfsl_pkg::DW'(s_data.robot_y);
        pre_pay_next.vdes = s_data.path_speed;
        pre_pay_next.dpsi = $signed(s_data.robot_heading - s_data.path_heading);
        pre_pay_next.curv = s_data.path_curvature;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (adv) begin
            pre_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pre_st_reg  <= pre_st_next;
            pre_pay_reg <= pre_pay_next;
        end
    end

    // Chain of CORDIC rotation cells.
    logic              valid_chain [0:N];
    pfsl_pkg::cordic_t st_chain    [0:N];
    pfsl_pkg::pay_t    pay_chain   [0:N];

    assign valid_chain[0] = pre_valid_reg;
    assign st_chain[0]    = pre_st_reg;
    assign pay_chain[0]   = pre_pay_reg;

    for (genvar g = 0; g < N; g++) begin : g_cell
        pfsl_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .stage_idx (pfsl_pkg::STAGE_IW'(g)),
            .in_valid  (valid_chain[g]),
            .in_st     (st_chain[g]),
            .in_pay    (pay_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_st    (st_chain[g+1]),
            .out_pay   (pay_chain[g+1])
        );
    end

    // Projection, gain products and clipping, ending in the output register.
    pfsl_law u_law (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (valid_chain[N]),
        .in_st        (st_chain[N]),
        .in_pay       (pay_chain[N]),
        .along_gain   (along_gain_reg),
        .cross_gain   (cross_gain_reg),
        .heading_gain (heading_gain_reg),
        .out_valid    (m_valid),
        .out_data     (m_data)
    );

endmodule

/* tb/path_following_steering_law_tb.sv */
// Self-checking testbench of the path-following steering law: directed and random poses.
`timescale 1ns / 100ps

module path_following_steering_law_tb;

    // Clock and reset.
    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    pfsl_pkg::in_t       s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    pfsl_pkg::out_t      m_data;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_index = pfsl_pkg::REG_ALONG_GAIN;
    logic [31:0]         cfg_data = '0;

    localparam int PIPE_DEPTH = 23;
    localparam int WATCHDOG_LIMIT = 20000;

    path_following_steering_law uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // The predictor keeps its own copy of the three gains.
    longint gain_along;
    longint gain_cross;
    longint gain_heading;

    // Commands predicted for each accepted pose, oldest first.
    pfsl_pkg::out_t command_queue[$];
    int     error_count = 0;
    int     idle_cycles = 0;
    bit     long_stall_req = 1'b0;

    // Arctangent table, as 32-bit binary angles.
    localparam longint ATAN_TURN[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    // Clip to the signed 32-bit range and note any clipping.
    function automatic longint clip32(input longint v, inout bit clipped);
        if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Rotation-mode CORDIC on a 16-bit binary angle, giving cosine and sine in Q2.30.
    function automatic void rotate_heading(input logic [15:0] angle, output longint c,
                                           output longint s);
        longint z, x, y, nx;
        bit     flip;
        z = longint'($signed({angle, 16'h0000}));
        x = 64'sd652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sh40000000) begin
            z -= 64'sh80000000;
            flip = 1'b1;
        end else if (z < -64'sh40000000) begin
            z += 64'sh80000000;
            flip = 1'b1;
        end
        for (int i = 0; i < pfsl_pkg::CORDIC_STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_TURN[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_TURN[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Work out the speed and turn-rate commands for one pose and path point.
    function automatic pfsl_pkg::out_t steering_command(input pfsl_pkg::in_t p);
        pfsl_pkg::out_t r;
        bit     clipped;
        longint cs, sn, dx, dy, along_err, cross_err, vdes, v, mag;
        longint dpsi, dpsi_rad, curv, omega;
        logic [15:0] hdiff;
        clipped = 1'b0;
        rotate_heading(p.path_heading, cs, sn);
        dx = longint'(p.path_x) - longint'(p.robot_x);
        dy = longint'(p.path_y) - longint'(p.robot_y);
        along_err = clip32((cs * dx + sn * dy) >>> 30, clipped);
        cross_err = clip32((sn * dx - cs * dy) >>> 30, clipped);
        vdes = longint'(p.path_speed);
        mag = vdes < 0 ? -vdes : vdes;
        // Speeds below the epsilon count as standing still.
        if (mag * 10000000 < (64'sd1 <<< pfsl_pkg::FRAC_BITS)) begin
            v = 0;
        end else begin
            v = clip32(vdes + ((gain_along * along_err) >>> pfsl_pkg::FRAC_BITS), clipped);
        end
        // A 16-bit difference wraps by itself; a half turn reads as minus pi.
        hdiff = p.robot_heading - p.path_heading;
        dpsi = longint'($signed(hdiff));
        dpsi_rad = (dpsi * 64'sd26986074949) >>> (48 - pfsl_pkg::FRAC_BITS);
        curv = clip32(longint'(p.path_curvature)
                      - ((gain_cross * cross_err) >>> pfsl_pkg::FRAC_BITS)
                      - ((gain_heading * dpsi_rad) >>> pfsl_pkg::FRAC_BITS), clipped);
        omega = clip32((v * curv) >>> pfsl_pkg::FRAC_BITS, clipped);
        r.speed_command = v[31:0];
        r.turn_rate_command = omega[31:0];
        r.saturated = clipped;
        return r;
    endfunction

    // Random gaps: mostly none or short, sometimes long.
    function automatic int random_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one pose and wait for its transfer; the prediction is queued on acceptance.
    // Valid stays high after the transfer so that poses can follow back to back.
    task automatic send_pose(input pfsl_pkg::in_t p, input bit allow_gaps);
        int gap;
        gap = allow_gaps ? random_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        do @(posedge aclk); while (!s_ready);
        command_queue.push_back(steering_command(p));
    endtask

    // Block until every expected command has arrived, then let the pipe drain.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (command_queue.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    // Write one gain register while the block is idle and mirror it locally.
    task automatic write_gain(input pfsl_pkg::cfg_reg_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            pfsl_pkg::REG_ALONG_GAIN:   gain_along = longint'($signed(value));
            pfsl_pkg::REG_CROSS_GAIN:   gain_cross = longint'($signed(value));
            pfsl_pkg::REG_HEADING_GAIN: gain_heading = longint'($signed(value));
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 15);
            3: return -$urandom_range(0, 15);
            4, 5: return $urandom;
            default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
        endcase
    endfunction

    // Poses near the path with moderate speeds reach the unclipped paths most often.
    function automatic pfsl_pkg::in_t random_pose();
        pfsl_pkg::in_t p;
        if ($urandom_range(0, 3) == 0) begin
            p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            p.robot_x = rand_word();
            p.robot_y = rand_word();
            p.path_x = p.robot_x + $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh0007FFFF;
            p.path_y = p.robot_y + $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh0007FFFF;
            p.robot_heading = 16'($urandom);
            p.path_heading = $urandom_range(0, 7) == 0 ? p.robot_heading + 16'h8000
                                                       : 16'($urandom);
            p.path_speed = rand_word();
            p.path_curvature = rand_word();
        end
        return p;
    endfunction

    function automatic pfsl_pkg::in_t make_pose(input logic [31:0] rx, ry,
                                                input logic [15:0] rh,
                                                input logic [31:0] px, py, spd,
                                                input logic [15:0] ph, input logic [31:0] crv);
        pfsl_pkg::in_t p;
        p.robot_x = rx;
        p.robot_y = ry;
        p.robot_heading = rh;
        p.path_x = px;
        p.path_y = py;
        p.path_speed = spd;
        p.path_heading = ph;
        p.path_curvature = crv;
        return p;
    endfunction

    // Directed poses: field extremes, half-turn error, zero and near-zero speed, clipping.
    task automatic test_directed();
        send_pose(make_pose(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        send_pose(make_pose(0, 0, 16'h8000, 32'h00010000, 0, 32'h00010000, 0, 0), 1'b0);
        send_pose(make_pose(0, 0, 0, 0, 32'h00010000, 32'h00010000, 16'h8000, 0), 1'b0);
        send_pose(make_pose(0, 0, 0, 0, 0, 32'd1, 16'h4000, 32'h00010000), 1'b0);
        send_pose(make_pose(0, 0, 0, 0, 0, -32'sd1, 16'hC000, 0), 1'b0);
        send_pose(make_pose(0, 0, 0, 0, 0, 32'd7, 0, 0), 1'b0);
        send_pose(make_pose(0, 0, 0, 0, 0, 32'd6, 0, 32'h00010000), 1'b0);
        send_pose(make_pose(0, 0, 0, 0, 0, -32'sd7, 0, 32'h00010000), 1'b0);
        send_pose(make_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 32'h80000000, 32'h80000000,
                            32'h7FFFFFFF, 16'h2000, 32'h7FFFFFFF), 1'b0);
        send_pose(make_pose(32'h80000000, 32'h80000000, 16'h0001, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h80000000, 16'hFFFF, 32'h80000000), 1'b0);
        send_pose(make_pose(32'h80000000, 0, 16'h7FFF, 32'h7FFFFFFF, 0,
                            32'h00010000, 16'h0000, 0), 1'b0);
        send_pose(make_pose(0, 32'h7FFFFFFF, 16'h8001, 0, 32'h80000000,
                            32'hFFFF0000, 16'h6000, 32'h00008000), 1'b0);
        send_pose(make_pose(32'h00050000, 32'hFFFB0000, 16'h1234, 32'h00060000, 32'hFFFA0000,
                            32'h00020000, 16'hE000, 32'hFFFF8000), 1'b0);
        send_pose(make_pose(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                            32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF), 1'b0);
        wait_drained();
    endtask

    // Random poses under one gain setting.
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_pose(random_pose(), 1'b1);
        wait_drained();
    endtask

    // Back-to-back poses while the result side holds off, so the input stalls.
    task automatic test_backpressure();
        long_stall_req = 1'b1;
        while (long_stall_req) @(posedge aclk);
        for (int i = 0; i < 80; i++) send_pose(random_pose(), 1'b0);
        wait_drained();
    endtask

    // Each gain through several values, extremes included.
    task automatic test_gain_sweep();
        logic [31:0] values[5];
        values = '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFF0000, 32'h00008000};
        foreach (values[v]) begin
            write_gain(pfsl_pkg::REG_ALONG_GAIN, values[v]);
            write_gain(pfsl_pkg::REG_CROSS_GAIN, values[(v + 1) % 5]);
            write_gain(pfsl_pkg::REG_HEADING_GAIN, values[(v + 2) % 5]);
            // A write to the unused index must leave the gains as they are.
            write_gain(pfsl_pkg::REG_NONE, $urandom);
            test_random(160);
        end
        write_gain(pfsl_pkg::REG_ALONG_GAIN, $urandom);
        write_gain(pfsl_pkg::REG_CROSS_GAIN, $urandom);
        write_gain(pfsl_pkg::REG_HEADING_GAIN, $urandom);
        test_random(150);
        write_gain(pfsl_pkg::REG_ALONG_GAIN, 32'h00010000);
        write_gain(pfsl_pkg::REG_CROSS_GAIN, 32'h00004000);
        write_gain(pfsl_pkg::REG_HEADING_GAIN, 32'h00010000);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
            end
            gap = random_gap();
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end
        end
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (command_queue.size() == 0) begin
                $error("unexpected result transfer: speed %0d", m_data.speed_command);
                error_count++;
            end else begin
                pfsl_pkg::out_t e;
                e = command_queue.pop_front();
                if (m_data.speed_command !== e.speed_command) begin
                    $error("speed_command expected %0d actual %0d",
                           e.speed_command, m_data.speed_command);
                    error_count++;
                end
                if (m_data.turn_rate_command !== e.turn_rate_command) begin
                    $error("turn_rate_command expected %0d actual %0d",
                           e.turn_rate_command, m_data.turn_rate_command);
                    error_count++;
                end
                if (m_data.saturated !== e.saturated) begin
                    $error("saturated expected %0b actual %0b", e.saturated, m_data.saturated);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: the run ends if no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        gain_along = 65536;
        gain_cross = 16384;
        gain_heading = 65536;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(500);
        test_gain_sweep();
        test_backpressure();
        wait_drained();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
